// ----- sv/lvs_pkg.sv -----
// lvs_pkg: constants, CORDIC arctangent table and the shared reading type for light_vector_steering.
// No dependencies.
package lvs_pkg;
    localparam int MaxSensorsDef  = 8;
    localparam int CordicStepsDef = 16;
    localparam int SumW           = 40;
    localparam int ZW             = 34;

    localparam logic [2:0] CfgThreshold = 3'd0;
    localparam logic [2:0] CfgMinAngle  = 3'd1;
    localparam logic [2:0] CfgMaxAngle  = 3'd2;
    localparam logic [2:0] CfgMaxSpeed  = 3'd3;
    localparam logic [2:0] CfgTurnGain  = 3'd4;

    // one queued reading
    typedef struct packed {
        logic [15:0] level;
        logic [15:0] bearing;
        logic        last;
    } t_item;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return {2'b00, v};
    endfunction
endpackage

// ----- sv/lvs_front.sv -----
// lvs_front: accepts readings and holds them in a two-entry queue for the back end.
// Depends on lvs_pkg.
module lvs_front import lvs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_light_level,
    input  logic [15:0] i_sensor_bearing,
    input  logic        i_frame_end,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{level: i_light_level, bearing: i_sensor_bearing,
                             last: i_frame_end};
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ----- sv/lvs_back.sv -----
// lvs_back: shared iterative CORDIC, accumulation and steering decision.
// Depends on lvs_pkg.
module lvs_back import lvs_pkg::*; #(
    parameter int MAX_SENSORS  = MaxSensorsDef,
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    input  logic [15:0] i_thr,
    input  logic [15:0] i_min_ang,
    input  logic [15:0] i_max_ang,
    input  logic [14:0] i_max_speed,
    input  logic [23:0] i_gain,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_take_control,
    output logic        o_go_straight,
    output logic [15:0] o_left_speed,
    output logic [15:0] o_right_speed
);
    localparam int CntW = $clog2(MAX_SENSORS + 1);
    localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_ROT = 4'd1, S_ACC = 4'd2, S_VEC = 4'd3,
                           S_T1 = 4'd4, S_T2 = 4'd5, S_CMP = 4'd6, S_MUL = 4'd7,
                           S_OUT = 4'd8, S_THR = 4'd9;

    logic [3:0]               r_st;
    logic [4:0]               r_i;
    logic signed [SumW-1:0]   r_x, r_y, r_sx, r_sy, r_len;
    logic signed [ZW-1:0]     r_z;
    logic [CntW-1:0]          r_cnt;
    logic                     r_last, r_vmode;
    logic signed [15:0]       r_bear;
    logic [39:0]              r_prod;
    logic                     r_ov;
    logic                     r_take, r_str;
    logic [15:0]              r_l, r_r;

    logic signed [SumW-1:0]   w_xs, w_ys, w_nx, w_ny;
    logic signed [ZW-1:0]     w_nz, w_at, w_za;
    logic                     w_dir, w_in, w_bpos;
    logic [15:0]              w_mag;
    logic [31:0]              w_zr;
    logic [14:0]              w_turn;

    // threshold times count
    function automatic logic [23:0] thr_times_cnt(input logic [15:0] t,
                                                  input logic [CntW-1:0] c);
        return 24'(t * c);
    endfunction

    // one micro-rotation per cycle
    always_comb begin
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        w_at = atan_lut(r_i);
        w_dir = r_vmode ? (r_y >= 0) : (r_z >= 0);
        if (w_dir) begin
            w_nx = r_x - w_ys; w_ny = r_y + w_xs;
        end else begin
            w_nx = r_x + w_ys; w_ny = r_y - w_xs;
        end
        if (r_vmode) begin
            w_nx = w_dir ? r_x + w_ys : r_x - w_ys;
            w_ny = w_dir ? r_y - w_xs : r_y + w_xs;
            w_nz = w_dir ? r_z + w_at : r_z - w_at;
        end else begin
            w_nz = w_dir ? r_z - w_at : r_z + w_at;
        end
    end

    // bearing rounding, window and turn magnitude
    assign w_zr   = r_z[31:0] + 32'h8000;
    assign w_in   = ($signed(r_bear) >= $signed(i_min_ang)) &&
                    ($signed(r_bear) <= $signed(i_max_ang));
    assign w_bpos = (r_bear > 0);
    assign w_mag  = r_bear[15] ? 16'(-r_bear) : r_bear;
    assign w_turn = (r_ov || r_prod[39:16] > {9'd0, i_max_speed}) ? i_max_speed
                                                                  : r_prod[30:16];
    assign w_za   = ZW'($signed(i_q_item.bearing)) <<< 16;

    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;
    assign o_valid = (r_st == S_OUT);
    assign o_take_control = r_take;
    assign o_go_straight  = r_str;
    assign o_left_speed   = r_l;
    assign o_right_speed  = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_sx <= '0; r_sy <= '0; r_cnt <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_last <= i_q_item.last; r_vmode <= 1'b0; r_i <= '0;
                    if (r_cnt < CntW'(MAX_SENSORS)) begin
                        // quadrant fold then rotate
                        r_y <= '0;
                        if (w_za > (ZW'(1) <<< 30)) begin
                            r_x <= -(SumW'(i_q_item.level) <<< 16);
                            r_z <= w_za - (ZW'(1) <<< 31);
                        end else if (w_za < -(ZW'(1) <<< 30)) begin
                            r_x <= -(SumW'(i_q_item.level) <<< 16);
                            r_z <= w_za + (ZW'(1) <<< 31);
                        end else begin
                            r_x <= SumW'(i_q_item.level) <<< 16;
                            r_z <= w_za;
                        end
                        r_st <= S_ROT;
                    end else begin
                        r_st <= i_q_item.last ? S_ACC : S_IDLE;
                    end
                end
                S_ROT: begin
                    r_x <= w_nx; r_y <= w_ny; r_z <= w_nz; r_i <= r_i + 5'd1;
                    if (r_i == LastStep) begin
                        r_st <= S_ACC;
                    end
                end
                S_ACC: begin
                    // r_x/r_y hold rotation result unless frame overflow skipped
                    if (r_i == LastStep + 5'd1 && !r_vmode) begin
                        r_sx <= r_sx + r_x; r_sy <= r_sy + r_y;
                        r_cnt <= r_cnt + CntW'(1);
                    end
                    r_i <= '0;
                    if (!r_last) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_st <= S_THR;
                    end
                end
                S_THR: begin
                    // set up vectoring on the sums
                    r_vmode <= 1'b1; r_i <= '0;
                    if (r_sx < 0) begin
                        r_x <= -r_sx; r_y <= -r_sy; r_z <= ZW'(1) <<< 31;
                    end else begin
                        r_x <= r_sx; r_y <= r_sy; r_z <= '0;
                    end
                    r_st <= S_VEC;
                end
                S_VEC: begin
                    r_x <= w_nx; r_y <= w_ny; r_z <= w_nz; r_i <= r_i + 5'd1;
                    if (r_i == LastStep) begin
                        r_st <= S_T1;
                    end
                end
                S_T1: begin
                    // keep length and angle, start threshold pass
                    r_len <= r_x;
                    r_bear <= $signed(w_zr[31:16]);
                    r_vmode <= 1'b0; r_i <= '0;
                    r_x <= SumW'({thr_times_cnt(i_thr, r_cnt), 16'd0});
                    r_y <= '0; r_z <= '0;
                    r_last <= 1'b0;
                    r_st <= S_T2;
                end
                S_T2: begin
                    // two passes at angle 0; the second starts from the first's x
                    r_x <= w_nx;
                    if (r_i == LastStep) begin
                        r_i <= '0;
                        r_y <= '0; r_z <= '0;
                        if (r_last) r_st <= S_CMP;
                        r_last <= 1'b1;
                    end else begin
                        r_y <= w_ny; r_z <= w_nz; r_i <= r_i + 5'd1;
                    end
                end
                S_CMP: begin
                    r_take <= r_len > r_x;
                    r_prod <= w_mag * i_gain;
                    r_ov   <= 1'b0;
                    r_st   <= S_MUL;
                end
                S_MUL: begin
                    r_str <= r_take && w_in;
                    if (!r_take) begin
                        r_l <= '0; r_r <= '0;
                    end else if (w_in) begin
                        r_l <= {1'b0, i_max_speed}; r_r <= {1'b0, i_max_speed};
                    end else if (w_bpos) begin
                        r_l <= -{1'b0, w_turn}; r_r <= {1'b0, w_turn};
                    end else begin
                        r_l <= {1'b0, w_turn}; r_r <= -{1'b0, w_turn};
                    end
                    r_sx <= '0; r_sy <= '0; r_cnt <= '0;
                    r_st <= S_OUT;
                end
                S_OUT: if (!i_stall) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/light_vector_steering.sv -----
// light_vector_steering: top level, configuration registers, front queue and back end.
// Depends on lvs_pkg, lvs_front, lvs_back.
//
// Each reading passes through the back end as a fetch, one CORDIC micro-rotation per cycle
// over CORDIC_STEPS iterations and an accumulate step; a reading beyond MAX_SENSORS is
// dropped. The frame's last reading then adds the vectoring pass and two threshold passes
// before the single result is offered, and the result holds until it is taken.
// A two-entry queue takes readings while the back end works and raises o_stall when full.
module light_vector_steering import lvs_pkg::*; #(
    parameter int MAX_SENSORS  = MaxSensorsDef,
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_light_level,
    input  logic [15:0] i_sensor_bearing,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_take_control,
    output logic        o_go_straight,
    output logic [15:0] o_left_speed,
    output logic [15:0] o_right_speed
);
    logic [15:0] r_thr, r_min, r_max;
    logic [14:0] r_spd;
    logic [23:0] r_gain;
    logic        w_qv, w_pop;
    t_item       w_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd6554; r_min <= 16'hFC72; r_max <= 16'd910;
            r_spd <= 15'd1280; r_gain <= 24'd42620;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgThreshold: r_thr <= i_cfg_data[15:0];
                CfgMinAngle:  r_min <= i_cfg_data[15:0];
                CfgMaxAngle:  r_max <= i_cfg_data[15:0];
                CfgMaxSpeed:  r_spd <= i_cfg_data[14:0];
                CfgTurnGain:  r_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lvs_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_light_level, .i_sensor_bearing,
        .i_frame_end, .o_q_valid(w_qv), .o_q_item(w_item), .i_q_pop(w_pop)
    );

    lvs_back #(.MAX_SENSORS(MAX_SENSORS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_item(w_item), .o_q_pop(w_pop),
        .i_thr(r_thr), .i_min_ang(r_min), .i_max_ang(r_max), .i_max_speed(r_spd),
        .i_gain(r_gain), .o_valid, .i_stall, .o_take_control, .o_go_straight,
        .o_left_speed, .o_right_speed
    );
endmodule
